[rtl/leb128_bounded_decoder_defines.svh]
// Assertion macros shared by the decoder's checker.
// No dependencies; take in by `include before use.
`ifndef LEB128_BOUNDED_DECODER_DEFINES_SVH
`define LEB128_BOUNDED_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LEB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LEB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/leb_pkg.sv]
// Types, constants and helpers for the bounded LEB128 decoder.
// No dependencies.
package leb_pkg;

  localparam logic [7:0] ContBit   = 8'h80;
  localparam logic [6:0] GroupMask = 7'h7F;
  localparam logic [6:0] SignBit   = 7'h40;
  localparam logic [6:0] MaxWidth  = 7'd64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_LONG  = 2'd2,
    ST_LARGE = 2'd3
  } leb_status_e;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  idx;
    logic [6:0]  width;
    logic        sgn;
  } leb_state_t;

  typedef struct packed {
    logic [63:0] value;
    leb_status_e status;
    logic [3:0]  bytes_used;
  } leb_result_t;

  // Width 0 decodes as 1, widths above 64 as 64.
  function automatic logic [6:0] clamp_width(logic [6:0] w);
    logic [6:0] r;
    if (w == 7'd0) begin
      r = 7'd1;
    end else if (w > MaxWidth) begin
      r = MaxWidth;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

[rtl/leb_step.sv]
// One-byte decode step: next accumulator state and optional result.
// Depends on leb_pkg.
module leb_step import leb_pkg::*; (
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  value_bits_i,
  input  logic        is_signed_i,
  input  logic        buffer_end_i,
  input  leb_state_t  state_i,
  output leb_state_t  state_o,
  output logic        res_valid_o,
  output leb_result_t res_o
);

  logic        first;
  logic [6:0]  width;
  logic        sgn;
  logic [63:0] acc_base;
  logic [6:0]  shift;
  logic [6:0]  pay;
  logic        cont;
  logic        last;
  logic [6:0]  rem7;
  logic [2:0]  rem;
  logic [6:0]  hi_mask;
  logic [6:0]  sx_mask;
  logic [6:0]  sx_bits;
  logic        too_large;
  logic [63:0] acc_new;
  logic [63:0] val_ext;
  logic [5:0]  nshift;
  logic [3:0]  used;

  assign first    = (state_i.idx == 4'd0);
  assign width    = first ? clamp_width(value_bits_i) : state_i.width;
  assign sgn      = first ? is_signed_i : state_i.sgn;
  assign acc_base = first ? 64'd0 : state_i.acc;
  assign pay      = data_byte_i[6:0] & GroupMask;
  assign cont     = (data_byte_i & ContBit) != 8'd0;
  assign used     = state_i.idx + 4'd1;

  // shift = 7 * idx
  assign shift = {state_i.idx, 3'b000} - {3'b000, state_i.idx};
  // final permitted byte once shift + 7 covers the width
  assign last  = ({1'b0, shift} + 8'd7) >= {1'b0, width};
  assign rem7  = width - shift;
  assign rem   = rem7[2:0];

  assign hi_mask = GroupMask << rem;
  assign sx_mask = GroupMask << (rem - 3'd1);
  assign sx_bits = pay & sx_mask;

  always_comb begin
    too_large = 1'b0;
    if (rem != 3'd7) begin
      if (sgn) begin
        // bits from N-1 upward must all match the sign
        too_large = (sx_bits != 7'd0) && (sx_bits != sx_mask);
      end else begin
        too_large = (pay & hi_mask) != 7'd0;
      end
    end
  end

  assign acc_new = shift[6] ? acc_base : (acc_base | ({57'd0, pay} << shift[5:0]));
  assign nshift  = shift[5:0] + 6'd7;

  always_comb begin
    val_ext = acc_new;
    if (sgn && (state_i.idx < 4'd9) && ((pay & SignBit) != 7'd0)) begin
      val_ext = acc_new | ({64{1'b1}} << nshift);
    end
  end

  always_comb begin
    state_o          = state_i;
    state_o.width    = width;
    state_o.sgn      = sgn;
    res_valid_o      = 1'b1;
    res_o.value      = 64'd0;
    res_o.status     = ST_OK;
    res_o.bytes_used = used;
    if (last && cont) begin
      res_o.status = ST_LONG;
    end else if (last && too_large) begin
      res_o.status = ST_LARGE;
    end else if (!cont) begin
      res_o.value = val_ext;
    end else if (buffer_end_i) begin
      res_o.status = ST_END;
    end else begin
      res_valid_o = 1'b0;
    end
    if (res_valid_o) begin
      state_o.acc = 64'd0;
      state_o.idx = 4'd0;
    end else begin
      state_o.acc = acc_new;
      state_o.idx = used;
    end
  end

endmodule

[rtl/leb_out_stage.sv]
// Result register with stream handshake toward the consumer.
// Depends on leb_pkg.
module leb_out_stage import leb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  leb_result_t res_i,
  output logic        free_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // [63:0] value, [67:64] bytes_used, rest zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  logic        valid_q, valid_d;
  leb_result_t res_q;

  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = load_i ? 1'b1 : (m_axis_tready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q.bytes_used, res_q.value};
  assign m_axis_tuser_o  = res_q.status;

endmodule

[rtl/leb128_bounded_decoder.sv]
// Bounded LEB128 decoder: takes one encoded byte per transfer and returns one result
// per value (ok, unexpected end, too long or too large) with its byte count. A byte
// is captured in the input register and then decoded into the result register; one
// byte is taken every cycle as long as the result register drains, and only consumer
// back-pressure on the result register slows the input.
// Depends on leb_pkg, leb_step and leb_out_stage.
module leb128_bounded_decoder import leb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [7:0]  s_axis_tuser_i,   // [6:0] value_bits, [7] is_signed
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] value, [67:64] bytes_used, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic [6:0]  s1_bits_q;
  logic        s1_sgn_q;
  logic        s1_end_q;
  leb_state_t  state_q, state_d;
  leb_result_t step_res;
  logic        step_res_valid;
  logic        out_free;
  logic        proc;
  logic        accept;

  assign proc            = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || proc;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_valid_d      = accept ? 1'b1 : (proc ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= s_axis_tdata_i;
      s1_bits_q <= s_axis_tuser_i[6:0];
      s1_sgn_q  <= s_axis_tuser_i[7];
      s1_end_q  <= s_axis_tlast_i;
    end
  end

  leb_step u_step (
    .data_byte_i  (s1_byte_q),
    .value_bits_i (s1_bits_q),
    .is_signed_i  (s1_sgn_q),
    .buffer_end_i (s1_end_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .res_valid_o  (step_res_valid),
    .res_o        (step_res)
  );

  leb_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (proc && step_res_valid),
    .res_i           (step_res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

[rtl/leb128_bounded_decoder_checker.sv]
// Port-level checks for the bounded LEB128 decoder, bound to the top level.
// Depends on leb_pkg and leb128_bounded_decoder_defines.svh.
`include "leb128_bounded_decoder_defines.svh"

module leb128_bounded_decoder_checker import leb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a stalled result keeps its transfer
  `LEB_ASSERT_NXT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "result changed while stalled")

  // input only stalls behind a full, blocked result register
  `LEB_ASSERT_IMP(a_in_stall_cause, clk_i, rst_ni,
    !s_axis_tready_o,
    m_axis_tvalid_o && !m_axis_tready_i,
    "input stalled without output back-pressure")

  // failed decodes carry a zero value
  `LEB_ASSERT_IMP(a_err_zero, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK),
    m_axis_tdata_o[63:0] == 64'd0,
    "nonzero value on error result")

  // byte count stays within one value's encoding
  `LEB_ASSERT_IMP(a_used_range, clk_i, rst_ni,
    m_axis_tvalid_o,
    (m_axis_tdata_o[67:64] != 4'd0) && (m_axis_tdata_o[67:64] <= 4'd10)
      && (m_axis_tdata_o[71:68] == 4'd0),
    "bytes_used out of range")

endmodule

bind leb128_bounded_decoder leb128_bounded_decoder_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[verif/tb_top.sv]
// Self-checking testbench for leb128_bounded_decoder: drives encoded bytes on the
// input stream and checks every result against a cycle-free LEB128 predictor.
// Depends on leb_pkg and the decoder RTL.
`timescale 1ns / 100ps

import leb_pkg::*;

typedef struct packed {
  logic [7:0] data;
  logic [6:0] vbits;
  logic       sgn;
  logic       last;
} leb_byte_t;

class varint_scoreboard;
  logic [63:0]  acc;
  int unsigned  idx;
  int unsigned  wid;
  bit           sgn;
  leb_result_t  pending_values[$];
  int unsigned  errors;

  function new();
    acc = '0;
    idx = 0;
    wid = 0;
    sgn = 1'b0;
    errors = 0;
  endfunction

  function bit close_value(logic [63:0] v, leb_status_e st, int unsigned used,
                           output leb_result_t res);
    res.value      = (st == ST_OK) ? v : 64'd0;
    res.status     = st;
    res.bytes_used = used[3:0];
    acc = '0;
    idx = 0;
    return 1'b1;
  endfunction

  // Returns 1 when this byte finishes a value or an attempt.
  function bit decode_byte(leb_byte_t b, output leb_result_t res);
    logic [6:0]  pay;
    logic [6:0]  up;
    logic [6:0]  want;
    logic [63:0] v;
    bit          cont;
    int unsigned k;
    int unsigned shift;
    int unsigned maxb;
    int unsigned rem;
    res = '0;
    pay = b.data[6:0];
    cont = b.data[7];
    if (idx == 0) begin
      wid = (b.vbits == 7'd0) ? 1 : ((b.vbits > 7'd64) ? 64 : int'(b.vbits));
      sgn = b.sgn;
      acc = '0;
    end
    k = idx;
    shift = 7 * k;
    maxb = (wid + 6) / 7;
    if (k >= maxb - 1) begin
      // last byte allowed for this width
      rem = wid - shift;
      if (cont) return close_value('0, ST_LONG, k + 1, res);
      if (rem < 7) begin
        up = pay >> rem;
        if (sgn) begin
          want = pay[rem-1] ? (7'h7F >> rem) : 7'd0;
          if (up != want) return close_value('0, ST_LARGE, k + 1, res);
        end else if (up != 7'd0) begin
          return close_value('0, ST_LARGE, k + 1, res);
        end
      end
    end
    if (shift < 64) acc |= {57'd0, pay} << shift;
    if (!cont) begin
      v = acc;
      if (sgn && (shift + 7 < 64) && pay[6]) v |= ~64'd0 << (shift + 7);
      return close_value(v, ST_OK, k + 1, res);
    end
    if (b.last) return close_value('0, ST_END, k + 1, res);
    idx = (k + 1) & 15;
    return 1'b0;
  endfunction

  function void take_byte(leb_byte_t b);
    leb_result_t r;
    if (decode_byte(b, r)) pending_values.push_back(r);
  endfunction

  function void match_result(logic [71:0] data, logic [1:0] user);
    leb_result_t exp_r;
    if (pending_values.size() == 0) begin
      $display("%0t: result with nothing expected: value=%h status=%0d used=%0d",
               $time, data[63:0], user, data[67:64]);
      errors++;
      return;
    end
    exp_r = pending_values.pop_front();
    if (data[63:0] !== exp_r.value) begin
      $display("%0t: value mismatch: expected %h, actual %h", $time, exp_r.value, data[63:0]);
      errors++;
    end
    if (user !== exp_r.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp_r.status, user);
      errors++;
    end
    if (data[67:64] !== exp_r.bytes_used) begin
      $display("%0t: bytes_used mismatch: expected %0d, actual %0d",
               $time, exp_r.bytes_used, data[67:64]);
      errors++;
    end
    if (data[71:68] !== 4'd0) begin
      $display("%0t: tdata pad mismatch: expected 0, actual %h", $time, data[71:68]);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending_values.size();
  endfunction
endclass

module tb_top;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] data_byte
  logic [7:0]  s_axis_tuser_i = '0;   // [6:0] value_bits, [7] is_signed
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;        // [63:0] value, [67:64] bytes_used
  logic [1:0]  m_axis_tuser_o;        // [1:0] status

  varint_scoreboard sb = new();
  int unsigned bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          src_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  int          hold_requests = 0;
  int          holds_seen = 0;

  leb128_bounded_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // Entered and left at a falling edge.
  task automatic send_byte(leb_byte_t b);
    int gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b.data;
    s_axis_tuser_i  <= {b.sgn, b.vbits};
    s_axis_tlast_i  <= b.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic put(logic [7:0] d, logic [6:0] vb, logic sg, logic last);
    leb_byte_t b;
    b.data = d;
    b.vbits = vb;
    b.sgn = sg;
    b.last = last;
    send_byte(b);
  endtask

  // Sender stays quiet until every expected result is out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_value();
    leb_byte_t b;
    int w_raw;
    int w;
    int maxb;
    int len;
    int mode;
    int rem;
    int p;
    int low;
    bit sg;
    w_raw = $urandom_range(0, 9);
    case (w_raw)
      0:       w_raw = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      1, 2, 3: w_raw = $urandom_range(1, 14);
      4, 5, 6: w_raw = $urandom_range(15, 40);
      default: w_raw = $urandom_range(41, 64);
    endcase
    w = (w_raw == 0) ? 1 : ((w_raw > 64) ? 64 : w_raw);
    maxb = (w + 6) / 7;
    sg = 1'($urandom_range(0, 1));
    mode = $urandom_range(0, 15);
    if (mode == 15) begin
      // raw noise, may leave a value open
      repeat ($urandom_range(1, 3)) begin
        b = leb_byte_t'($urandom);
        send_byte(b);
      end
      return;
    end
    if (mode == 12 && maxb == 1) mode = 13;
    case (mode)
      12:      len = $urandom_range(1, maxb - 1);
      13, 14:  len = maxb;
      default: len = $urandom_range(1, maxb);
    endcase
    for (int k = 0; k < len; k++) begin
      p = $urandom_range(0, 127);
      b.vbits = (k == 0) ? w_raw[6:0] : 7'($urandom);
      b.sgn   = (k == 0) ? sg : 1'($urandom);
      b.last  = 1'b0;
      if (k == len - 1) begin
        if (k == maxb - 1 && mode < 12) begin
          rem = w - 7 * k;
          if (rem < 7) begin
            low = p & ((1 << rem) - 1);
            p = (sg && low[rem-1]) ? (low | ((127 << rem) & 127)) : low;
          end
        end
        case (mode)
          12:      b.last = 1'b1;
          13:      b.last = 1'($urandom);
          default: b.last = 1'($urandom);
        endcase
      end
      b.data = {(k < len - 1) || (mode == 12) || (mode == 13), p[6:0]};
      send_byte(b);
    end
  endtask

  task automatic run_values(int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) send_value();
  endtask

  task automatic directed();
    put(8'h01, 7'd1, 1'b0, 1'b0);          // u1 ok
    put(8'h02, 7'd0, 1'b0, 1'b1);          // width zero as 1, too large at end
    put(8'h7F, 7'd1, 1'b1, 1'b0);          // s1 minus one
    put(8'h40, 7'd1, 1'b1, 1'b0);          // s1 surplus bits not sign
    put(8'h80, 7'd8, 1'b0, 1'b1);          // open value at end
    put(8'hFF, 7'd8, 1'b0, 1'b0);
    put(8'h01, 7'd0, 1'b0, 1'b1);          // complete value at end
    put(8'h80, 7'd8, 1'b1, 1'b0);
    put(8'h80, 7'd0, 1'b0, 1'b1);          // too long wins over end
    put(8'h80, 7'd8, 1'b0, 1'b0);
    put(8'h00, 7'd127, 1'b1, 1'b0);        // padded zero
    put(8'h40, 7'd7, 1'b1, 1'b0);          // s7 sign extension
    repeat (9) put(8'h80, 7'd127, 1'b1, 1'b0);
    put(8'h7F, 7'd0, 1'b0, 1'b0);          // width above 64, top bit only
  endtask

  // Result side: random back-pressure plus one long hold on request.
  initial begin : sink
    int burst;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17);
        m_axis_tready_i <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.match_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed();
    drain();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    run_values(120);
    // keep offering while the result side is held off
    src_gaps = 1'b0;
    hold_requests++;
    run_values(40);
    drain();
    sink_gaps = 1'b0;
    run_values(50);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    run_values(110);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    run_values(80);
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
